// ===== rtl/core/pfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and helpers of the Playfair stream cipher
// Letter constants, square layout, request format and square lookup.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned SQ_DIM         = 5;
  localparam int unsigned NCELLS         = SQ_DIM * SQ_DIM;
  localparam int unsigned CELL_W         = 5;
  localparam int unsigned CELLS_PER_WORD = 12;
  localparam int unsigned CFG_DATA_W     = 60;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned FIFO_DEPTH     = 4;

  localparam logic [7:0] LETTER_A    = 8'd65;
  localparam logic [7:0] LETTER_Z    = 8'd90;
  localparam logic [7:0] LOWER_A     = 8'd97;
  localparam logic [7:0] LOWER_Z     = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] SPACE_CHAR  = 8'd32;

  localparam logic [6:0] ABSENT_RST = 7'd74;
  localparam logic [6:0] SUBST_RST  = 7'd73;
  localparam logic [6:0] FILL_RST   = 7'd88;

  typedef enum logic [1:0] {
    ST_LETTER  = 2'd0,
    ST_INVALID = 2'd1,
    ST_ODD     = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_LOW = 3'd0,
    REG_CELLS_MID = 3'd1,
    REG_CELL_LAST = 3'd2,
    REG_ABSENT    = 3'd3,
    REG_SUBST     = 3'd4,
    REG_FILL      = 3'd5
  } cfg_reg_e;

  typedef logic [NCELLS-1:0][CELL_W-1:0] square_t;

  typedef struct packed {
    logic [6:0] absent;
    logic [6:0] subst;
    logic [6:0] fill;
  } cfg_letters_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } loc_t;

  typedef struct packed {
    logic       is_pair;
    logic       dec;
    logic [7:0] a;
    logic [7:0] b;
    status_e    status;
    logic       last;
  } op_t;

  function automatic logic is_upper(logic [7:0] c);
    return (c >= LETTER_A) && (c <= LETTER_Z);
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= LOWER_A) && (c <= LOWER_Z);
  endfunction

  function automatic logic [2:0] adv(logic [2:0] x, logic dec);
    logic [2:0] res;
    if (dec) begin
      res = (x == 3'd0) ? 3'(SQ_DIM - 1) : x - 3'd1;
    end else begin
      res = (x == 3'(SQ_DIM - 1)) ? 3'd0 : x + 3'd1;
    end
    return res;
  endfunction

  function automatic logic [4:0] cell_index(logic [2:0] row, logic [2:0] col);
    return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
  endfunction

  function automatic loc_t locate(square_t sq, logic [7:0] letter);
    loc_t res;
    res = '0;
    for (int r = 0; r < SQ_DIM; r++) begin
      for (int c = 0; c < SQ_DIM; c++) begin
        if (LETTER_A + {3'b000, sq[r * SQ_DIM + c]} == letter) begin
          res.row = 3'(r);
          res.col = 3'(c);
        end
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pfc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_cfg: configuration registers
// Holds the 5x5 square and the absent, substitute and filler letters.
// ----------------------------------------------------------------------------
module pfc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output pfc_pkg::square_t                 cells_o,
  output pfc_pkg::cfg_letters_t            letters_o
);
  import pfc_pkg::*;

  square_t      cells_q;
  cfg_letters_t letters_q;

  assign cfg_ready_o = 1'b1;
  assign cells_o     = cells_q;
  assign letters_o   = letters_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q          <= '0;
      letters_q.absent <= ABSENT_RST;
      letters_q.subst  <= SUBST_RST;
      letters_q.fill   <= FILL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CELLS_LOW: begin
          for (int k = 0; k < CELLS_PER_WORD; k++) begin
            cells_q[k] <= cfg_data_i[k * CELL_W +: CELL_W];
          end
        end
        REG_CELLS_MID: begin
          for (int k = 0; k < CELLS_PER_WORD; k++) begin
            cells_q[CELLS_PER_WORD + k] <= cfg_data_i[k * CELL_W +: CELL_W];
          end
        end
        REG_CELL_LAST: cells_q[NCELLS-1] <= cfg_data_i[CELL_W-1:0];
        REG_ABSENT:    letters_q.absent  <= cfg_data_i[6:0];
        REG_SUBST:     letters_q.subst   <= cfg_data_i[6:0];
        REG_FILL:      letters_q.fill    <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pfc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_front: input classifier
// Folds and checks each byte, pairs letters, and issues pair and status
// requests, at most two per byte, one per cycle into the queue unless full.
// ----------------------------------------------------------------------------
module pfc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
  input  logic                  s_axis_tuser,   // [0] func
  input  logic                  s_axis_tlast,
  input  pfc_pkg::cfg_letters_t letters_i,
  output logic                  push_o,
  output pfc_pkg::op_t          op_o,
  input  logic                  full_i
);
  import pfc_pkg::*;

  logic [7:0] held_q, held_d;
  logic       held_v_q, held_v_d;
  logic       err_q, err_d;
  op_t        p0_q, p1_q;
  logic       p0_v_q, p1_v_q;

  logic       acc;
  logic [7:0] txt, c1, c2, enc_c;
  logic       first_v, eol_v;
  op_t        first_op, eol_op;

  function automatic op_t pair_op(logic [7:0] a, logic [7:0] b, logic dec);
    op_t o;
    o         = '0;
    o.is_pair = 1'b1;
    o.dec     = dec;
    o.a       = a;
    o.b       = b;
    o.status  = ST_LETTER;
    return o;
  endfunction

  function automatic op_t status_op(status_e st);
    op_t o;
    o        = '0;
    o.status = st;
    return o;
  endfunction

  assign push_o        = p0_v_q && !full_i;
  assign op_o          = p0_q;
  assign s_axis_tready = !p1_v_q && (!p0_v_q || push_o);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign txt           = s_axis_tdata;

  always_comb begin
    c1    = is_lower(txt) ? txt - CASE_OFFSET : txt;
    c2    = (c1 == {1'b0, letters_i.absent}) ? {1'b0, letters_i.subst} : c1;
    enc_c = is_lower(c2) ? c2 - CASE_OFFSET : c2;
  end

  always_comb begin
    held_d   = held_q;
    held_v_d = held_v_q;
    err_d    = err_q;
    first_v  = 1'b0;
    first_op = status_op(ST_EMPTY);
    eol_v    = 1'b0;
    eol_op   = status_op(ST_EMPTY);
    if (!s_axis_tuser) begin
      if (is_upper(enc_c)) begin
        if (!held_v_q) begin
          held_d   = enc_c;
          held_v_d = 1'b1;
        end else if (held_q == enc_c) begin
          first_v  = 1'b1;
          first_op = pair_op(held_q, {1'b0, letters_i.fill}, 1'b0);
        end else begin
          first_v  = 1'b1;
          first_op = pair_op(held_q, enc_c, 1'b0);
          held_v_d = 1'b0;
        end
      end
    end else if (!err_q && txt != SPACE_CHAR) begin
      if (!is_upper(txt) || txt == {1'b0, letters_i.absent}) begin
        first_v  = 1'b1;
        first_op = status_op(ST_INVALID);
        err_d    = 1'b1;
        held_v_d = 1'b0;
      end else if (!held_v_q) begin
        held_d   = txt;
        held_v_d = 1'b1;
      end else begin
        first_v  = 1'b1;
        first_op = pair_op(held_q, txt, 1'b1);
        held_v_d = 1'b0;
      end
    end
    if (s_axis_tlast) begin
      if (held_v_d) begin
        eol_v  = 1'b1;
        eol_op = s_axis_tuser ? status_op(ST_ODD)
                              : pair_op(held_d, {1'b0, letters_i.subst}, 1'b0);
      end else if (!first_v) begin
        eol_v = 1'b1;
      end
      if (eol_v) begin
        eol_op.last = 1'b1;
      end else begin
        first_op.last = 1'b1;
      end
      held_d   = '0;
      held_v_d = 1'b0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      held_v_q <= 1'b0;
      err_q    <= 1'b0;
      p0_q     <= '0;
      p1_q     <= '0;
      p0_v_q   <= 1'b0;
      p1_v_q   <= 1'b0;
    end else begin
      if (acc) begin
        held_q   <= held_d;
        held_v_q <= held_v_d;
        err_q    <= err_d;
        if (first_v) begin
          p0_q   <= first_op;
          p0_v_q <= 1'b1;
          p1_q   <= eol_op;
          p1_v_q <= eol_v;
        end else begin
          p0_q   <= eol_op;
          p0_v_q <= eol_v;
          p1_v_q <= 1'b0;
        end
      end else if (push_o) begin
        p0_q   <= p1_q;
        p0_v_q <= p1_v_q;
        p1_v_q <= 1'b0;
      end
    end
  end

  a_slots_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_v_q |-> p0_v_q)
    else $error("second request slot filled while first is empty");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast) |=> (!held_v_q && !err_q))
    else $error("line state not cleared after end of line");

endmodule
`default_nettype wire

// ===== rtl/core/pfc_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_fifo: request queue
// Short first-in first-out queue of requests between classifier and cipher.
// ----------------------------------------------------------------------------
module pfc_fifo #(
  parameter int unsigned Depth = pfc_pkg::FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pfc_pkg::op_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output pfc_pkg::op_t rdata_o,
  output logic         empty_o
);
  import pfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("request queue overrun or underrun");

endmodule
`default_nettype wire

// ===== rtl/core/pfc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_back: cipher engine
// Locates both letters of a pair in the square, then sends the two cipher
// letters one per cycle unless stalled; a status request is a single result.
// ----------------------------------------------------------------------------
module pfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfc_pkg::square_t cells_i,
  input  logic             empty_i,
  input  pfc_pkg::op_t     op_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_letter
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast
);
  import pfc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SECOND,
    S_STATUS
  } state_e;

  state_e     state_q;
  op_t        job_q;
  loc_t       loc_a_q, loc_b_q;
  logic       m_valid_q, m_last_q;
  logic [7:0] m_data_q;
  status_e    m_status_q;

  logic       out_free, fin, send_v;
  logic       same_row, same_col, sel_second;
  logic [2:0] row1, col1, row2, col2, row_sel, col_sel;
  logic [4:0] idx;
  logic [7:0] letter;

  assign out_free = !m_valid_q || m_axis_tready;
  assign send_v   = out_free && (state_q != S_IDLE);
  assign fin      = out_free && (state_q == S_SECOND || state_q == S_STATUS);
  assign pop_o    = !empty_i && (state_q == S_IDLE || fin);

  always_comb begin
    same_row   = (loc_a_q.row == loc_b_q.row);
    same_col   = (loc_a_q.col == loc_b_q.col);
    sel_second = (state_q == S_SECOND);
    if (same_row) begin
      row1 = loc_a_q.row;
      col1 = adv(loc_a_q.col, job_q.dec);
      row2 = loc_b_q.row;
      col2 = adv(loc_b_q.col, job_q.dec);
    end else if (same_col) begin
      row1 = adv(loc_a_q.row, job_q.dec);
      col1 = loc_a_q.col;
      row2 = adv(loc_b_q.row, job_q.dec);
      col2 = loc_b_q.col;
    end else begin
      row1 = loc_a_q.row;
      col1 = loc_b_q.col;
      row2 = loc_b_q.row;
      col2 = loc_a_q.col;
    end
    row_sel = sel_second ? row2 : row1;
    col_sel = sel_second ? col2 : col1;
    idx     = cell_index(row_sel, col_sel);
    letter  = LETTER_A + {3'b000, cells_i[idx]};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      job_q      <= '0;
      loc_a_q    <= '0;
      loc_b_q    <= '0;
      m_valid_q  <= 1'b0;
      m_last_q   <= 1'b0;
      m_data_q   <= '0;
      m_status_q <= ST_LETTER;
    end else begin
      if (send_v) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
        end
        S_FIRST: begin
          if (out_free) begin
            m_data_q   <= letter;
            m_status_q <= ST_LETTER;
            m_last_q   <= 1'b0;
            state_q    <= S_SECOND;
          end
        end
        S_SECOND: begin
          if (out_free) begin
            m_data_q   <= letter;
            m_status_q <= ST_LETTER;
            m_last_q   <= job_q.last;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            m_data_q   <= '0;
            m_status_q <= job_q.status;
            m_last_q   <= job_q.last;
          end
        end
        default: begin
        end
      endcase
      if (pop_o) begin
        job_q   <= op_i;
        loc_a_q <= locate(cells_i, op_i.a);
        loc_b_q <= locate(cells_i, op_i.b);
        state_q <= op_i.is_pair ? S_FIRST : S_STATUS;
      end else if (fin) begin
        state_q <= S_IDLE;
      end
    end
  end

  a_letters_from_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIRST || state_q == S_SECOND) |-> job_q.is_pair)
    else $error("letter phase entered for a status request");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIRST && out_free) |=>
      (m_valid_q && !m_last_q && m_status_q == ST_LETTER))
    else $error("first letter of a pair sent with wrong flags");

endmodule
`default_nettype wire

// ===== rtl/core/playfair_stream_cipher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_stream_cipher: streaming Playfair encoder and decoder
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tdata text_byte, tuser func,
//                                             tlast end_of_line
//   m_axis    out  m_axis_tvalid/tready       tdata out_letter, tuser status,
//                                             tlast last_of_line
//   cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// A byte is classified in the cycle it is accepted; it issues up to two
// requests, moved into the queue one per cycle while it is not full.
// The cipher engine sends a pair as two letters, one in S_FIRST and one in
// S_SECOND (square lookup overlapped with the pop), and a status in S_STATUS.
// Reset clears line state, queue and output register; no clearing pass.
// Either side may stall; the queue decouples classifier and engine.
// ----------------------------------------------------------------------------
module playfair_stream_cipher #(
  parameter int unsigned FifoDepth = pfc_pkg::FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  logic                           s_axis_tuser,   // [0] func
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] out_letter
  output logic [1:0]                     m_axis_tuser,   // [1:0] status
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pfc_pkg::*;

  square_t      cells;
  cfg_letters_t letters;
  logic         push, full, pop, empty;
  op_t          wr_op, rd_op;

  pfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cells_o     (cells),
    .letters_o   (letters)
  );

  pfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .letters_i     (letters),
    .push_o        (push),
    .op_o          (wr_op),
    .full_i        (full)
  );

  pfc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_op),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rd_op),
    .empty_o (empty)
  );

  pfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cells_i       (cells),
    .empty_i       (empty),
    .op_i          (rd_op),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
